[sv/tsvc_pkg.sv]
// Shared types and constants for the trade size variation coefficient block.
package tsvc_pkg;

   localparam int TS_W       = 28;
   localparam int VOL_W      = 32;
   localparam int CNT_W      = 24;
   localparam int FRAC_W     = 8;
   localparam int DVD_W      = VOL_W + FRAC_W;
   localparam int VAR_W      = 24;
   localparam int QUO_W      = 48;
   localparam int Q_SHIFT    = 32;
   localparam int ROOT_STEPS = 24;
   localparam int MIN_BARS   = 3;

   typedef struct packed {
      logic [VOL_W-1:0] volume;
      logic [CNT_W-1:0] trade_count;
      logic             finite;
      logic             last_bar;
   } req_type;

   typedef struct packed {
      logic [VAR_W-1:0] variation;
      logic             defined;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV, ST_SQR, ST_ACC, ST_CHK, ST_MSS, ST_MQN,
      ST_MTN, ST_MDN, ST_QDIV, ST_ROOT, ST_DONE
   } state_type;

   typedef enum logic [1:0] {MUL_SS, MUL_QN, MUL_TN, MUL_DN} mul_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        div_step;
      logic        sqr;
      logic        acc;
      logic        mul_load;
      logic        mul_step;
      logic        mul_save;
      mul_sel_type mul_sel;
      logic        qdiv_load;
      logic        qdiv_step;
      logic        root_load;
      logic        root_step;
      logic        finish;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic ok;
   } sts_type;

endpackage

[sv/tsvc_ctrl.sv]
// Controller state machine that sequences the datapath for each item.
module tsvc_ctrl #(
   parameter int MAX_SAMPLES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tsvc_pkg::cmd_type cmd,
   input  tsvc_pkg::sts_type sts
);

   localparam int CW     = $clog2(MAX_SAMPLES + 1);
   localparam int SW     = tsvc_pkg::TS_W + CW;
   localparam int PW     = 2 * tsvc_pkg::TS_W + 3 * CW;
   localparam int QDIV_N = PW + tsvc_pkg::Q_SHIFT;
   localparam int CNTW   = $clog2(QDIV_N + 2);

   tsvc_pkg::state_type state_ff, state_in;
   logic [CNTW-1:0]     cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != tsvc_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_valid_in = cmd.finish ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsvc_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff + 1'b1;
      unique case (state_ff) inside
         tsvc_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = tsvc_pkg::ST_DIV;
            end
         end
         tsvc_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNTW'(tsvc_pkg::DVD_W - 1)) begin
               state_in = tsvc_pkg::ST_SQR;
            end
         end
         tsvc_pkg::ST_SQR: begin
            cmd.sqr  = 1'b1;
            state_in = tsvc_pkg::ST_ACC;
         end
         tsvc_pkg::ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = sts.last ? tsvc_pkg::ST_CHK : tsvc_pkg::ST_IDLE;
         end
         tsvc_pkg::ST_CHK: begin
            cnt_in   = '0;
            state_in = sts.ok ? tsvc_pkg::ST_MSS : tsvc_pkg::ST_DONE;
         end
         tsvc_pkg::ST_MSS, tsvc_pkg::ST_MQN, tsvc_pkg::ST_MTN, tsvc_pkg::ST_MDN: begin
            case (state_ff)
               tsvc_pkg::ST_MSS: cmd.mul_sel = tsvc_pkg::MUL_SS;
               tsvc_pkg::ST_MQN: cmd.mul_sel = tsvc_pkg::MUL_QN;
               tsvc_pkg::ST_MTN: cmd.mul_sel = tsvc_pkg::MUL_TN;
               default:          cmd.mul_sel = tsvc_pkg::MUL_DN;
            endcase
            if (cnt_ff == '0) begin
               cmd.mul_load = 1'b1;
            end else if (cnt_ff <= CNTW'(SW)) begin
               cmd.mul_step = 1'b1;
            end else begin
               cmd.mul_save = 1'b1;
               cnt_in       = '0;
               case (state_ff)
                  tsvc_pkg::ST_MSS: state_in = tsvc_pkg::ST_MQN;
                  tsvc_pkg::ST_MQN: state_in = tsvc_pkg::ST_MTN;
                  tsvc_pkg::ST_MTN: state_in = tsvc_pkg::ST_MDN;
                  default:          state_in = tsvc_pkg::ST_QDIV;
               endcase
            end
         end
         tsvc_pkg::ST_QDIV: begin
            if (cnt_ff == '0) begin
               cmd.qdiv_load = 1'b1;
            end else if (cnt_ff <= CNTW'(QDIV_N)) begin
               cmd.qdiv_step = 1'b1;
            end else begin
               cnt_in   = '0;
               state_in = tsvc_pkg::ST_ROOT;
            end
         end
         tsvc_pkg::ST_ROOT: begin
            if (cnt_ff == '0) begin
               cmd.root_load = 1'b1;
            end else if (cnt_ff <= CNTW'(tsvc_pkg::ROOT_STEPS)) begin
               cmd.root_step = 1'b1;
            end else begin
               cnt_in   = '0;
               state_in = tsvc_pkg::ST_DONE;
            end
         end
         tsvc_pkg::ST_DONE: begin
            cnt_in = '0;
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = tsvc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tsvc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[sv/tsvc_dp.sv]
// Datapath with trade size divider, accumulators, multiplier, divider and square root.
module tsvc_dp #(
   parameter int MAX_SAMPLES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  tsvc_pkg::req_type req_data,
   output tsvc_pkg::rsp_type rsp_data,
   input  tsvc_pkg::cmd_type cmd,
   output tsvc_pkg::sts_type sts
);

   localparam int CW  = $clog2(MAX_SAMPLES + 1);
   localparam int SW  = tsvc_pkg::TS_W + CW;
   localparam int QW  = 2 * tsvc_pkg::TS_W + CW;
   localparam int PW  = 2 * tsvc_pkg::TS_W + 3 * CW;
   localparam int DW  = PW + tsvc_pkg::Q_SHIFT;
   localparam int DV  = tsvc_pkg::DVD_W;
   localparam int TW  = tsvc_pkg::TS_W;
   localparam int QU  = tsvc_pkg::QUO_W;

   tsvc_pkg::req_type req_ff;
   logic [DV-1:0]          dvd_ff;
   logic [tsvc_pkg::CNT_W:0] rem_ff;
   logic [DV-1:0]          quo_ff;
   logic [2*TW-1:0]        tsq_ff;
   logic [SW-1:0]          sum_ff;
   logic [QW-1:0]          sq_ff;
   logic [CW-1:0]          n_ff;
   logic [PW-1:0]          ma_ff, macc_ff, s2_ff, num_ff, top_ff, den_ff;
   logic [SW-1:0]          mb_ff;
   logic [DW-1:0]          qd_ff;
   logic [PW:0]            qr_ff;
   logic [QU:0]            qq_ff;
   logic                   sat_ff;
   logic [QU-1:0]          rq_ff, rres_ff, rbit_ff;
   tsvc_pkg::rsp_type      rsp_ff;

   logic [tsvc_pkg::CNT_W:0] div_sh;
   logic                   div_ge;
   logic [TW-1:0]          ts_sat;
   logic                   use_bar;
   logic                   ok;
   logic [PW:0]            qd_sh;
   logic                   qd_ge;
   logic [QU:0]            qq_next;
   logic [QU:0]            root_t;

   assign div_sh  = {rem_ff[tsvc_pkg::CNT_W-1:0], dvd_ff[DV-1]};
   assign div_ge  = div_sh >= {1'b0, req_ff.trade_count};
   assign ts_sat  = (quo_ff[DV-1:TW] != '0) ? '1 : quo_ff[TW-1:0];
   assign use_bar = req_ff.finite && (req_ff.trade_count != '0)
                    && (n_ff < CW'(MAX_SAMPLES));
   assign ok      = (n_ff >= CW'(tsvc_pkg::MIN_BARS)) && (sum_ff != '0);
   assign qd_sh   = {qr_ff[PW-1:0], qd_ff[DW-1]};
   assign qd_ge   = qd_sh >= {1'b0, den_ff};
   assign qq_next = {qq_ff[QU-1:0], qd_ge};
   assign root_t  = {1'b0, rres_ff} + {1'b0, rbit_ff};

   assign sts.last = req_ff.last_bar;
   assign sts.ok   = ok;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         sq_ff  <= '0;
         n_ff   <= '0;
      end else if (cmd.finish) begin
         sum_ff <= '0;
         sq_ff  <= '0;
         n_ff   <= '0;
      end else if (cmd.acc && use_bar) begin
         sum_ff <= sum_ff + SW'(ts_sat);
         sq_ff  <= sq_ff + QW'(tsq_ff);
         n_ff   <= n_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
         dvd_ff <= {req_data.volume, {tsvc_pkg::FRAC_W{1'b0}}};
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[DV-2:0], 1'b0};
         rem_ff <= div_ge ? div_sh - {1'b0, req_ff.trade_count} : div_sh;
         quo_ff <= {quo_ff[DV-2:0], div_ge};
      end
      if (cmd.sqr) begin
         tsq_ff <= ts_sat * ts_sat;
      end
      if (cmd.mul_load) begin
         macc_ff <= '0;
         case (cmd.mul_sel)
            tsvc_pkg::MUL_SS: begin
               ma_ff <= PW'(sum_ff);
               mb_ff <= sum_ff;
            end
            tsvc_pkg::MUL_QN: begin
               ma_ff <= PW'(sq_ff);
               mb_ff <= SW'(n_ff);
            end
            tsvc_pkg::MUL_TN: begin
               ma_ff <= num_ff;
               mb_ff <= SW'(n_ff);
            end
            default: begin
               ma_ff <= s2_ff;
               mb_ff <= SW'(n_ff - 1'b1);
            end
         endcase
      end else if (cmd.mul_step) begin
         if (mb_ff[0]) begin
            macc_ff <= macc_ff + ma_ff;
         end
         ma_ff <= {ma_ff[PW-2:0], 1'b0};
         mb_ff <= {1'b0, mb_ff[SW-1:1]};
      end
      if (cmd.mul_save) begin
         case (cmd.mul_sel)
            tsvc_pkg::MUL_SS: s2_ff  <= macc_ff;
            tsvc_pkg::MUL_QN: num_ff <= (macc_ff >= s2_ff) ? macc_ff - s2_ff : '0;
            tsvc_pkg::MUL_TN: top_ff <= macc_ff;
            default:          den_ff <= macc_ff;
         endcase
      end
      if (cmd.qdiv_load) begin
         qd_ff  <= {top_ff, {tsvc_pkg::Q_SHIFT{1'b0}}};
         qr_ff  <= '0;
         qq_ff  <= '0;
         sat_ff <= 1'b0;
      end else if (cmd.qdiv_step) begin
         qd_ff <= {qd_ff[DW-2:0], 1'b0};
         qr_ff <= qd_ge ? qd_sh - {1'b0, den_ff} : qd_sh;
         if (!sat_ff) begin
            qq_ff  <= qq_next;
            sat_ff <= qq_next[QU];
         end
      end
      if (cmd.root_load) begin
         rq_ff   <= qq_ff[QU-1:0];
         rres_ff <= '0;
         rbit_ff <= QU'(1) << (QU - 2);
      end else if (cmd.root_step) begin
         if ({1'b0, rq_ff} >= root_t) begin
            rq_ff   <= rq_ff - root_t[QU-1:0];
            rres_ff <= (rres_ff >> 1) + rbit_ff;
         end else begin
            rres_ff <= rres_ff >> 1;
         end
         rbit_ff <= rbit_ff >> 2;
      end
      if (cmd.finish) begin
         rsp_ff.defined <= ok;
         if (!ok) begin
            rsp_ff.variation <= '0;
         end else if (sat_ff) begin
            rsp_ff.variation <= '1;
         end else begin
            rsp_ff.variation <= rres_ff[tsvc_pkg::VAR_W-1:0];
         end
      end
   end

endmodule

[sv/trade_size_variation_coefficient_core.sv]
// Top level of the trade size variation coefficient block.
// Each input item is one bar: volume, trade count, a finite flag and a
// last-of-series flag. A usable bar has its trade size formed as
// volume * 256 / trade_count in Q20.8, saturating, and accumulated.
// A bar with last_bar set gives exactly one result item after it is
// accumulated: the sample coefficient of variation in Q8.16 and a flag
// that is set when at least three bars were used and their sum is
// positive. The accumulators then clear for the next series.
// One item is handled at a time. A bar that does not end a series goes
// through the bit-serial trade size divider. A bar that ends a defined
// series adds four shift-add multiplications with an SW-bit multiplier,
// a restoring division of a PW-bit numerator shifted left by 32 and a
// square root, where SW = 28 + CW, PW = 56 + 3 * CW and
// CW = clog2(MAX_SAMPLES+1). The result sits in an output register, so the
// next item is taken while it waits under rsp_stall; a later result waits
// until that one has gone. Synchronous reset returns the controller to
// idle, drops rsp_valid and clears the accumulators.
module trade_size_variation_coefficient_core #(
   parameter int MAX_SAMPLES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tsvc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tsvc_pkg::rsp_type rsp_data
);

   tsvc_pkg::cmd_type cmd;
   tsvc_pkg::sts_type sts;

   tsvc_ctrl #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   tsvc_dp #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .sts      (sts)
   );

endmodule
